[design/csvg_pkg.sv]
package csvg_pkg;

  localparam int MAX_LOD  = 10;
  localparam int LOD_W    = 4;
  localparam int RAD_W    = 24;
  localparam int COORD_W  = 11;
  localparam int POS_W    = 25;
  localparam int IDX_W    = 21;
  localparam int FACE_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = RAD_W;

  // Root search width: the unrounded quotient never exceeds twice the radius.
  localparam int ZW   = RAD_W + 1;
  localparam int M2W  = 2 * COORD_W;
  localparam int SW   = 2 * COORD_W;
  localparam int R2W  = 2 * RAD_W;
  localparam int TW   = R2W + M2W + 2;
  localparam int WW   = ZW + SW;
  localparam int DW   = TW + 2;
  localparam int LANES = 3;

  localparam logic [LOD_W-1:0] LOD_RESET    = LOD_W'(4);
  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_LOD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b1;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_Z = 3'd0,
    FACE_NEG_Z = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_POS_X = 3'd4,
    FACE_NEG_X = 3'd5
  } face_e;

  typedef struct packed {
    logic             neg_a;
    logic             neg_b;
    logic             oor;
    logic [IDX_W-1:0] idx;
  } side_t;

  typedef struct packed {
    logic [TW-1:0] rem;
    logic [WW-1:0] w;
    logic [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic [SW-1:0]         s;
    side_t                 side;
    lane_t [LANES-1:0]     lane;
  } step_t;

endpackage

[design/csvg_if.sv]
interface csvg_in_if;
  import csvg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;

  modport source (output valid, output col, output row, input ready);
  modport sink (input valid, input col, input row, output ready);
endinterface

interface csvg_out_if;
  import csvg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FACE_W-1:0]        face;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [IDX_W-1:0]         vertex_index;
  logic                     out_of_range;
  logic                     last;

  modport source (output valid, output face, output pos_x, output pos_y, output pos_z,
                  output vertex_index, output out_of_range, output last, input ready);
  modport sink (input valid, input face, input pos_x, input pos_y, input pos_z,
                input vertex_index, input out_of_range, input last, output ready);
endinterface

[design/cube_sphere_vertex_gen_unit.sv]
// Cube-to-sphere vertex generator. Each input transfer carries one grid point
// (col, row) of a face grid with 2^lod+1 points per side; the block answers with
// six output transfers, one per cube face in the order +z, -z, -y, +y, +x, -x,
// the sixth marked by last. Coordinates are signed Q8.16, exactly rounded to the
// nearest step (ties away from zero). A point with col or row above 2^lod still
// gives six transfers, flagged out_of_range, with zero coordinates and index.
// The single output port delivers the six faces of a point one per cycle while
// the sink is ready, and so sets the rate at which grid points are accepted.
// From input transfer to the first face a point passes two setup stages (squares,
// then the radius product), 25 stages of a bit-per-stage root search and the
// output register. Points enter the pipeline while earlier faces are still
// being delivered; once the tail holds a point, a stalled sink freezes the whole
// pipeline. lod and radius must be written through the configuration port while
// idle; the block does not enforce this. A lod of 0 behaves as 1, above 10 as 10.
module cube_sphere_vertex_gen_unit import csvg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  csvg_in_if.sink              in_i,
  csvg_out_if.source           out_o
);

  // Configuration registers.
  logic [LOD_W-1:0] lod_q;
  logic [RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lod_q    <= LOD_RESET;
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOD:    lod_q    <= cfg_wdata_i[LOD_W-1:0];
        REG_RADIUS: radius_q <= cfg_wdata_i[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  // Pipeline advance. Every stage moves together when the tail can hand its
  // point to the output register or the tail holds nothing.
  logic tail_v;
  logic load;
  logic en;
  logic busy_q;
  logic out_xfer;
  face_e face_q;

  assign out_xfer = busy_q && out_o.ready;
  assign load     = tail_v && (!busy_q || (out_xfer && face_q == FACE_NEG_X));
  assign en       = !tail_v || load;
  assign in_i.ready = en;

  // Stage 1: grid geometry. With n = 2^lod, u and v become a = 2col - n and
  // b = n - 2row over the common denominator 2n, and 0.5 becomes n.
  logic [LOD_W-1:0]       lv;
  logic [COORD_W-1:0]     n;
  logic                   oor;
  logic signed [COORD_W+1:0] a_s;
  logic signed [COORD_W+1:0] b_s;
  logic [COORD_W-1:0]     ma;
  logic [COORD_W-1:0]     mb;
  logic [IDX_W:0]         idx_full;
  logic [M2W+1:0]         s_full;

  always_comb begin
    if (lod_q == '0) begin
      lv = LOD_W'(1);
    end else if (lod_q > LOD_W'(MAX_LOD)) begin
      lv = LOD_W'(MAX_LOD);
    end else begin
      lv = lod_q;
    end
    n   = COORD_W'(1) << lv;
    oor = (in_i.col > n) || (in_i.row > n);
    a_s = $signed({1'b0, in_i.col, 1'b0}) - $signed({2'b00, n});
    b_s = $signed({2'b00, n}) - $signed({1'b0, in_i.row, 1'b0});
    ma  = a_s[COORD_W+1] ? COORD_W'(-a_s) : COORD_W'(a_s);
    mb  = b_s[COORD_W+1] ? COORD_W'(-b_s) : COORD_W'(b_s);
    if (oor) begin
      ma = '0;
      mb = '0;
    end
    s_full   = (M2W+2)'(ma * ma) + (M2W+2)'(mb * mb) + (M2W+2)'(n * n);
    idx_full = ((IDX_W+1)'(in_i.row) << lv) + (IDX_W+1)'(in_i.row) + (IDX_W+1)'(in_i.col);
  end

  logic                v1_q;
  logic [M2W-1:0]      m2_q [LANES];
  logic [R2W-1:0]      r2_q;
  logic [SW-1:0]       s1_q;
  side_t               side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q[0]       <= M2W'(ma * ma);
      m2_q[1]       <= M2W'(mb * mb);
      m2_q[2]       <= M2W'(n * n);
      r2_q          <= radius_q * radius_q;
      s1_q          <= s_full[SW-1:0];
      side1_q.neg_a <= a_s[COORD_W+1];
      side1_q.neg_b <= b_s[COORD_W+1];
      side1_q.oor   <= oor;
      side1_q.idx   <= oor ? '0 : idx_full[IDX_W-1:0];
    end
  end

  // Stage 2: target of each root search, (2 * radius * m)^2.
  logic  v2_q;
  step_t step2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [R2W+M2W-1:0] prod;
    if (en) begin
      step2_q.s    <= s1_q;
      step2_q.side <= side1_q;
      for (int j = 0; j < LANES; j++) begin
        prod = r2_q * m2_q[j];
        step2_q.lane[j].rem <= {prod, 2'b00};
        step2_q.lane[j].w   <= '0;
        step2_q.lane[j].z   <= '0;
      end
    end
  end

  // Root search: z = floor(2 * radius * m / sqrt(s)) for each lane.
  step_t step_tail;

  csvg_mag_pipe u_mag_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .step_i  (step2_q),
    .valid_o (tail_v),
    .step_o  (step_tail)
  );

  // Rounding: the nearest step is (z + 1) / 2, then the sign of the term.
  logic signed [POS_W-1:0] pos_t [LANES];

  always_comb begin
    logic [ZW:0]      zr;
    logic [POS_W-1:0] mag;
    logic             neg;
    for (int j = 0; j < LANES; j++) begin
      zr  = (ZW+1)'(step_tail.lane[j].z) + (ZW+1)'(1);
      mag = {1'b0, zr[RAD_W:1]};
      case (j)
        0:       neg = step_tail.side.neg_a;
        1:       neg = step_tail.side.neg_b;
        default: neg = 1'b0;
      endcase
      pos_t[j] = neg ? $signed(-mag) : $signed(mag);
      if (step_tail.side.oor) begin
        pos_t[j] = '0;
      end
    end
  end

  // Output register: holds one point and walks through its six faces.
  logic signed [POS_W-1:0] pu_q;
  logic signed [POS_W-1:0] pv_q;
  logic signed [POS_W-1:0] ph_q;
  logic signed [POS_W-1:0] mh_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      face_q <= FACE_POS_Z;
    end else if (load) begin
      busy_q <= 1'b1;
      face_q <= FACE_POS_Z;
    end else if (out_xfer) begin
      if (face_q == FACE_NEG_X) begin
        busy_q <= 1'b0;
        face_q <= FACE_POS_Z;
      end else begin
        face_q <= face_e'(face_q + FACE_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pu_q  <= pos_t[0];
      pv_q  <= pos_t[1];
      ph_q  <= pos_t[2];
      mh_q  <= -pos_t[2];
      idx_q <= step_tail.side.idx;
      oor_q <= step_tail.side.oor;
    end
  end

  always_comb begin
    case (face_q)
      FACE_POS_Z: begin
        out_o.pos_x = pu_q; out_o.pos_y = pv_q; out_o.pos_z = ph_q;
      end
      FACE_NEG_Z: begin
        out_o.pos_x = pu_q; out_o.pos_y = pv_q; out_o.pos_z = mh_q;
      end
      FACE_NEG_Y: begin
        out_o.pos_x = pu_q; out_o.pos_y = mh_q; out_o.pos_z = pv_q;
      end
      FACE_POS_Y: begin
        out_o.pos_x = pu_q; out_o.pos_y = ph_q; out_o.pos_z = pv_q;
      end
      FACE_POS_X: begin
        out_o.pos_x = ph_q; out_o.pos_y = pu_q; out_o.pos_z = pv_q;
      end
      default: begin
        out_o.pos_x = mh_q; out_o.pos_y = pu_q; out_o.pos_z = pv_q;
      end
    endcase
  end

  assign out_o.valid        = busy_q;
  assign out_o.face         = face_q;
  assign out_o.vertex_index = idx_q;
  assign out_o.out_of_range = oor_q;
  assign out_o.last         = (face_q == FACE_NEG_X);

`ifndef NO_ASSERTIONS
  a_face_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && face_q != FACE_NEG_X |=> face_q == face_e'($past(face_q) + FACE_W'(1)))
    else $error("face did not advance by one after a transfer");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && oor_q |-> pu_q == '0 && pv_q == '0 && ph_q == '0 && idx_q == '0)
    else $error("off-grid point carries nonzero payload");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_v && busy_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while the pipeline tail is blocked");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && face_q == FACE_POS_Z)
    else $error("new point did not start at the first face");
`endif

endmodule

[design/csvg_mag_pipe.sv]
// Restoring square-root style search, one quotient bit per stage, three lanes.
// Each lane finds the largest z with z*z*s <= rem, keeping w = z*s.
module csvg_mag_pipe import csvg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  step_t step_i,
  output logic  valid_o,
  output step_t step_o
);

  logic  [ZW-1:0] vld_q;
  step_t          stage_q [ZW];
  step_t          stage_d [ZW];

  for (genvar i = 0; i < ZW; i++) begin : g_stage
    localparam int K = ZW - 1 - i;
    step_t cur;
    logic  cur_v;

    if (i == 0) begin : g_first
      assign cur   = step_i;
      assign cur_v = valid_i;
    end else begin : g_next
      assign cur   = stage_q[i-1];
      assign cur_v = vld_q[i-1];
    end

    always_comb begin
      logic [DW-1:0] dlt;
      stage_d[i] = cur;
      for (int j = 0; j < LANES; j++) begin
        dlt = (DW'(cur.lane[j].w) << (K + 1)) + (DW'(cur.s) << (2 * K));
        if (dlt <= DW'(cur.lane[j].rem)) begin
          stage_d[i].lane[j].rem  = cur.lane[j].rem - dlt[TW-1:0];
          stage_d[i].lane[j].w    = cur.lane[j].w + (WW'(cur.s) << K);
          stage_d[i].lane[j].z[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  assign valid_o = vld_q[ZW-1];
  assign step_o  = stage_q[ZW-1];

endmodule
